// ===== src/radar_report_frame_deframer_assert.svh =====
// Assertion macros shared by the deframer modules.
`ifndef RADAR_REPORT_FRAME_DEFRAMER_ASSERT_SVH
`define RADAR_REPORT_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define RRFD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rrfd: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define RRFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rrfd: next-cycle check failed");

`endif

// ===== src/rrfd_pkg.sv =====
// Types, frame constants and register codes of the report frame deframer.
package rrfd_pkg;

  typedef enum logic [3:0] {
    PH_H1,
    PH_H2,
    PH_H3,
    PH_H4,
    PH_L1,
    PH_L2,
    PH_PAY,
    PH_F1,
    PH_F2,
    PH_F3,
    PH_F4
  } phase_t;

  typedef enum logic {
    CFG_IDX_MAX_LEN = 1'b0,
    CFG_IDX_TIMEOUT = 1'b1
  } cfg_idx_t;

  localparam logic [7:0] REP_HDR [4] = '{8'hF4, 8'hF3, 8'hF2, 8'hF1};
  localparam logic [7:0] REP_FTR [4] = '{8'hF8, 8'hF7, 8'hF6, 8'hF5};
  localparam logic [7:0] CFG_HDR [4] = '{8'hFD, 8'hFC, 8'hFB, 8'hFA};
  localparam logic [7:0] CFG_FTR [4] = '{8'h04, 8'h03, 8'h02, 8'h01};

  localparam logic [7:0]  MAX_LEN_RESET = 8'd250;
  localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
  localparam logic [15:0] IDLE_MAX      = 16'hFFFF;
  localparam logic [15:0] REPORT_LEN    = 16'd4;

  typedef struct packed {
    logic        rep_ok;
    logic        cfg_ok;
    logic [31:0] distance;
  } frame_evt_t;

  function automatic logic [7:0] want_byte(logic is_cfg, logic footer, logic [1:0] pos);
    logic [7:0] w;
    if (footer) begin
      w = is_cfg ? CFG_FTR[pos] : REP_FTR[pos];
    end else begin
      w = is_cfg ? CFG_HDR[pos] : REP_HDR[pos];
    end
    return w;
  endfunction

endpackage

// ===== src/rrfd_feed_if.sv =====
// Input channel: one received byte or one millisecond tick per beat.
interface rrfd_feed_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, func, rx_byte, input ready);
  modport sink (input valid, func, rx_byte, output ready);
endinterface

// ===== src/rrfd_report_if.sv =====
// Result channel: frame events, latched distance and link status per beat.
interface rrfd_report_if;
  logic        valid;
  logic        ready;
  logic        report_valid;
  logic [31:0] distance_bits;
  logic        config_frame_seen;
  logic        connected;

  modport source (output valid, report_valid, distance_bits, config_frame_seen, connected,
                  input ready);
  modport sink (input valid, report_valid, distance_bits, config_frame_seen, connected,
                output ready);
endinterface

// ===== src/rrfd_parser.sv =====
// Frame parser: header, length, payload and footer tracking per received byte.
`include "radar_report_frame_deframer_assert.svh"

module rrfd_parser
  import rrfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step_en,
  input  logic [7:0] rx_byte,
  input  logic [7:0] max_payload_len,
  output frame_evt_t evt
);

  phase_t      phase, phase_next;
  logic        frame_is_config, frame_is_config_next;
  logic [15:0] declared_length, declared_length_next;
  logic [15:0] payload_count, payload_count_next;
  logic [31:0] payload_shift, payload_shift_next;
  logic [31:0] last_distance, last_distance_next;

  logic [3:0]  ftr_off;
  logic [15:0] len_full;
  logic [15:0] count_inc;

  assign ftr_off   = 4'(phase) - 4'(PH_F1);
  assign len_full  = {rx_byte, declared_length[7:0]};
  assign count_inc = payload_count + 16'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_H1;
      frame_is_config <= 1'b0;
      declared_length <= '0;
      payload_count   <= '0;
      payload_shift   <= '0;
      last_distance   <= '0;
    end else begin
      phase           <= phase_next;
      frame_is_config <= frame_is_config_next;
      declared_length <= declared_length_next;
      payload_count   <= payload_count_next;
      payload_shift   <= payload_shift_next;
      last_distance   <= last_distance_next;
    end
  end

  always_comb begin
    phase_next           = phase;
    frame_is_config_next = frame_is_config;
    declared_length_next = declared_length;
    payload_count_next   = payload_count;
    payload_shift_next   = payload_shift;
    last_distance_next   = last_distance;
    evt.rep_ok           = 1'b0;
    evt.cfg_ok           = 1'b0;
    if (step_en) begin
      unique case (phase)
        PH_H1: begin
          if (rx_byte == REP_HDR[0]) begin
            frame_is_config_next = 1'b0;
            phase_next           = PH_H2;
          end else if (rx_byte == CFG_HDR[0]) begin
            frame_is_config_next = 1'b1;
            phase_next           = PH_H2;
          end
        end
        PH_H2, PH_H3, PH_H4: begin
          if (rx_byte == want_byte(frame_is_config, 1'b0, phase[1:0])) begin
            phase_next = phase_t'(4'(phase) + 4'd1);
          end else begin
            phase_next = PH_H1;
          end
        end
        PH_L1: begin
          declared_length_next = {8'h00, rx_byte};
          phase_next           = PH_L2;
        end
        PH_L2: begin
          declared_length_next = len_full;
          payload_count_next   = '0;
          phase_next           = (len_full > {8'h00, max_payload_len}) ? PH_H1 : PH_PAY;
        end
        PH_PAY: begin
          payload_shift_next = {rx_byte, payload_shift[31:8]};
          payload_count_next = count_inc;
          if (count_inc >= declared_length) begin
            phase_next = PH_F1;
          end
        end
        PH_F1, PH_F2, PH_F3: begin
          if (rx_byte == want_byte(frame_is_config, 1'b1, ftr_off[1:0])) begin
            phase_next = phase_t'(4'(phase) + 4'd1);
          end else begin
            phase_next = PH_H1;
          end
        end
        PH_F4: begin
          if (rx_byte == want_byte(frame_is_config, 1'b1, ftr_off[1:0])) begin
            if (frame_is_config) begin
              evt.cfg_ok = 1'b1;
            end else if (declared_length == REPORT_LEN) begin
              evt.rep_ok         = 1'b1;
              last_distance_next = payload_shift;
            end
          end
          phase_next = PH_H1;
        end
        default: begin
          phase_next = PH_H1;
        end
      endcase
    end
    evt.distance = last_distance_next;
  end

  `RRFD_ASSERT_SAME(a_rep_is_report_len4, evt.rep_ok, (declared_length == REPORT_LEN) && !frame_is_config)
  `RRFD_ASSERT_NEXT(a_long_frame_dropped, step_en && (phase == PH_L2) && (len_full > {8'h00, max_payload_len}), phase == PH_H1)

endmodule

// ===== src/radar_report_frame_deframer.sv =====
// Top level of the report frame deframer: config registers, idle timer, result register.
//
//   channel  dir  beat content
//   feed     in   func, rx_byte (one byte or one millisecond tick)
//   report   out  report_valid, distance_bits, config_frame_seen, connected
//   cfg      in   cfg_write, cfg_index, cfg_data (two registers, write only)
//
// One beat per cycle unless the feed stalls; its result is registered when it is taken.
// The feed side stalls only while the result register is full and the sink holds ready low.
// Reset is synchronous: the parser waits for a header, the idle timer is zero and the
// registers return to a 250-byte payload limit and a 3000 ms timeout.
`include "radar_report_frame_deframer_assert.svh"

module radar_report_frame_deframer
  import rrfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  rrfd_feed_if.sink          feed,
  rrfd_report_if.source      report,
  input  logic               cfg_write,
  input  cfg_idx_t           cfg_index,
  input  logic [15:0]        cfg_data
);

  logic [7:0]  max_payload_len;
  logic [15:0] link_timeout_ms;
  logic [15:0] idle_ms, idle_ms_next;
  logic        out_valid;
  logic        out_report_valid;
  logic [31:0] out_distance_bits;
  logic        out_config_frame_seen;
  logic        out_connected;

  logic        accept;
  logic        step_en;
  frame_evt_t  evt;

  assign feed.ready = !out_valid || report.ready;
  assign accept     = feed.valid && feed.ready;
  assign step_en    = accept && !feed.func;

  rrfd_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .step_en         (step_en),
    .rx_byte         (feed.rx_byte),
    .max_payload_len (max_payload_len),
    .evt             (evt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_len <= MAX_LEN_RESET;
      link_timeout_ms <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_IDX_MAX_LEN: max_payload_len <= cfg_data[7:0];
        CFG_IDX_TIMEOUT: link_timeout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    idle_ms_next = idle_ms;
    if (accept && feed.func) begin
      if (idle_ms != IDLE_MAX) begin
        idle_ms_next = idle_ms + 16'd1;
      end
    end else if (evt.rep_ok || evt.cfg_ok) begin
      idle_ms_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_ms   <= '0;
      out_valid <= 1'b0;
    end else begin
      idle_ms <= idle_ms_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (report.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_report_valid      <= evt.rep_ok;
      out_distance_bits     <= evt.distance;
      out_config_frame_seen <= evt.cfg_ok;
      out_connected         <= idle_ms_next < link_timeout_ms;
    end
  end

  assign report.valid             = out_valid;
  assign report.report_valid      = out_report_valid;
  assign report.distance_bits     = out_distance_bits;
  assign report.config_frame_seen = out_config_frame_seen;
  assign report.connected         = out_connected;

  `RRFD_ASSERT_NEXT(a_frame_clears_idle, evt.rep_ok || evt.cfg_ok, idle_ms == 16'd0)
  `RRFD_ASSERT_NEXT(a_tick_counts, accept && feed.func && (idle_ms != IDLE_MAX), idle_ms == $past(idle_ms) + 16'd1)
  `RRFD_ASSERT_NEXT(a_drained_when_idle, out_valid && report.ready && !accept, !out_valid)

endmodule

// ===== verif/radar_report_frame_deframer_tb.sv =====
// Self-checking testbench for the report frame deframer: frame traffic, ticks and link status.
module radar_report_frame_deframer_tb
  import rrfd_pkg::*;
();

  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic        rep_ok;
    logic [31:0] dist_bits;
    logic        cfg_ok;
    logic        conn;
  } report_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  cfg_idx_t cfg_index;
  logic [15:0] cfg_data;

  rrfd_feed_if feed ();
  rrfd_report_if report ();

  radar_report_frame_deframer DUT (
    .clk(clk),
    .rst(rst),
    .feed(feed),
    .report(report),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  phase_t rx_phase;
  logic in_config;
  logic [15:0] frame_len;
  logic [15:0] pay_seen;
  logic [31:0] pay_window;
  logic [31:0] held_distance;
  logic [15:0] quiet_ms;
  logic [7:0] len_limit;
  logic [15:0] timeout_ms;

  report_t expected_reports[$];
  int bad_beats = 0;
  int beats_sent = 0;
  int ticks_sent = 0;
  int reports_seen = 0;
  int config_frames_seen = 0;
  int cycle_count = 0;
  int sink_hold = 0;
  bit no_idle = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic advance_deframer(input logic tick, input logic [7:0] b, output report_t r);
    logic [7:0] want;
    logic [1:0] pos;
    r.rep_ok = 1'b0;
    r.cfg_ok = 1'b0;
    if (tick) begin
      if (quiet_ms != IDLE_MAX) quiet_ms = quiet_ms + 16'd1;
    end else begin
      case (rx_phase)
        PH_H1: begin
          if (b == REP_HDR[0]) begin
            in_config = 1'b0;
            rx_phase = PH_H2;
          end else if (b == CFG_HDR[0]) begin
            in_config = 1'b1;
            rx_phase = PH_H2;
          end
        end
        PH_H2, PH_H3, PH_H4: begin
          pos = 2'(rx_phase - PH_H1);
          want = in_config ? CFG_HDR[pos] : REP_HDR[pos];
          rx_phase = (b == want) ? phase_t'(rx_phase + 1) : PH_H1;
        end
        PH_L1: begin
          frame_len = {8'd0, b};
          rx_phase = PH_L2;
        end
        PH_L2: begin
          frame_len = {b, frame_len[7:0]};
          pay_seen = 16'd0;
          rx_phase = (frame_len > {8'd0, len_limit}) ? PH_H1 : PH_PAY;
        end
        PH_PAY: begin
          pay_window = {b, pay_window[31:8]};
          pay_seen = pay_seen + 16'd1;
          if (pay_seen >= frame_len) rx_phase = PH_F1;
        end
        PH_F1, PH_F2, PH_F3: begin
          pos = 2'(rx_phase - PH_F1);
          want = in_config ? CFG_FTR[pos] : REP_FTR[pos];
          rx_phase = (b == want) ? phase_t'(rx_phase + 1) : PH_H1;
        end
        PH_F4: begin
          want = in_config ? CFG_FTR[3] : REP_FTR[3];
          if (b == want) begin
            if (in_config) begin
              r.cfg_ok = 1'b1;
              quiet_ms = 16'd0;
            end else if (frame_len == REPORT_LEN) begin
              r.rep_ok = 1'b1;
              held_distance = pay_window;
              quiet_ms = 16'd0;
            end
          end
          rx_phase = PH_H1;
        end
        default: begin
          rx_phase = PH_H1;
        end
      endcase
    end
    r.dist_bits = held_distance;
    r.conn = (quiet_ms < timeout_ms);
  endtask

  task automatic send_beat(input logic tick, input logic [7:0] b);
    int gap;
    report_t want;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      feed.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    feed.valid <= 1'b1;
    feed.func <= tick;
    feed.rx_byte <= tick ? 8'($urandom_range(0, 255)) : b;
    @(posedge clk);
    while (!feed.ready) @(posedge clk);
    advance_deframer(tick, b, want);
    expected_reports.push_back(want);
    beats_sent++;
    if (tick) ticks_sent++;
    if (want.rep_ok) reports_seen++;
    if (want.cfg_ok) config_frames_seen++;
  endtask

  task automatic send_frame(input logic is_cfg, input logic [15:0] len, input logic [31:0] word,
                            input int corrupt_at, input int tick_pct);
    logic [7:0] frame_bytes[$];
    logic [7:0] filler;
    int pay_bytes;
    pay_bytes = (len == 0) ? 1 : ((len > {8'd0, len_limit}) ? 4 : int'(len));
    for (int i = 0; i < 4; i++) frame_bytes.push_back(is_cfg ? CFG_HDR[i] : REP_HDR[i]);
    frame_bytes.push_back(len[7:0]);
    frame_bytes.push_back(len[15:8]);
    for (int i = 0; i < pay_bytes; i++) begin
      filler = 8'($urandom_range(0, 255));
      frame_bytes.push_back(i < 4 ? word[8*i +: 8] : filler);
    end
    for (int i = 0; i < 4; i++) frame_bytes.push_back(is_cfg ? CFG_FTR[i] : REP_FTR[i]);
    if (corrupt_at >= 0 && corrupt_at < frame_bytes.size()) begin
      filler = 8'($urandom_range(1, 255));
      frame_bytes[corrupt_at] = frame_bytes[corrupt_at] ^ filler;
    end
    foreach (frame_bytes[i]) begin
      if ($urandom_range(0, 99) < tick_pct) send_beat(1'b1, 8'd0);
      send_beat(1'b0, frame_bytes[i]);
    end
  endtask

  task automatic settle();
    feed.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] len_word, input logic [15:0] timeout_word);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= CFG_IDX_MAX_LEN;
    cfg_data <= len_word;
    @(posedge clk);
    cfg_index <= CFG_IDX_TIMEOUT;
    cfg_data <= timeout_word;
    @(posedge clk);
    cfg_write <= 1'b0;
    len_limit = len_word[7:0];
    timeout_ms = timeout_word;
  endtask

  task automatic test_clean_frames();
    send_frame(1'b0, REPORT_LEN, 32'h0000_0000, -1, 0);
    send_frame(1'b0, REPORT_LEN, 32'hFFFF_FFFF, -1, 0);
    send_frame(1'b1, 16'd0, $urandom, -1, 0);
    send_frame(1'b0, 16'd0, $urandom, -1, 0);
    send_frame(1'b0, 16'd7, $urandom, -1, 0);
    send_frame(1'b1, 16'd2, $urandom, -1, 0);
    send_frame(1'b0, REPORT_LEN, $urandom, -1, 0);
  endtask

  task automatic test_broken_frames();
    send_beat(1'b0, REP_HDR[0]);
    send_frame(1'b0, REPORT_LEN, $urandom, -1, 0);
    send_frame(1'b0, REPORT_LEN, $urandom, 13, 0);
    send_frame(1'b1, REPORT_LEN, $urandom, 2, 0);
    send_frame(1'b0, 16'd251, $urandom, -1, 0);
    send_frame(1'b0, 16'h0104, $urandom, -1, 0);
    send_frame(1'b0, REPORT_LEN, $urandom, -1, 50);
  endtask

  task automatic test_register_extremes();
    logic [7:0] junk;
    configure(16'hFF00, 16'd0);
    send_frame(1'b0, 16'd0, $urandom, -1, 0);
    send_frame(1'b1, 16'd0, $urandom, -1, 0);
    send_frame(1'b0, REPORT_LEN, $urandom, -1, 0);
    repeat (3) send_beat(1'b1, 8'd0);
    junk = 8'($urandom_range(0, 255));
    configure({junk, 8'hFF}, 16'd1);
    send_frame(1'b0, 16'd255, $urandom, -1, 0);
    send_frame(1'b0, REPORT_LEN, $urandom, -1, 0);
    repeat (2) send_beat(1'b1, 8'd0);
    send_frame(1'b1, 16'd1, $urandom, -1, 0);
  endtask

  task automatic test_link_timeout();
    configure({8'd0, MAX_LEN_RESET}, 16'd20);
    no_idle = 1'b1;
    send_frame(1'b1, 16'd0, 32'd0, -1, 0);
    repeat (24) send_beat(1'b1, 8'd0);
    send_frame(1'b1, 16'd0, 32'd0, -1, 0);
    settle();
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic();
    int start;
    int pick;
    int len_pick;
    logic is_cfg;
    logic [31:0] word;
    logic [7:0] junk;
    logic [15:0] timeout_word;
    start = beats_sent;
    for (int p = 0; p < 6; p++) begin
      junk = 8'($urandom_range(0, 255));
      case (p)
        0: configure({junk, 8'd255}, 16'($urandom_range(1, 40)));
        1: configure({junk, 8'($urandom_range(0, 255))}, 16'($urandom_range(1, 40)));
        2: configure({junk, 8'd12}, 16'd1);
        3: begin
          timeout_word = 16'($urandom_range(1, 65535));
          configure({junk, 8'($urandom_range(4, 255))}, timeout_word);
        end
        4: configure({junk, 8'd0}, IDLE_MAX);
        default: configure({junk, 8'($urandom_range(0, 255))}, 16'($urandom_range(1, 200)));
      endcase
      no_idle = (p == 2);
      while (beats_sent - start < (p + 1) * 48) begin
        pick = $urandom_range(0, 99);
        is_cfg = ($urandom_range(0, 3) == 0);
        len_pick = $urandom_range(0, 1) ? 4 : $urandom_range(0, 12);
        case ($urandom_range(0, 9))
          0: word = 32'h0000_0000;
          1: word = 32'hFFFF_FFFF;
          default: word = $urandom;
        endcase
        if (pick < 65) begin
          send_frame(is_cfg, 16'(len_pick), word, -1, 8);
        end else if (pick < 80) begin
          send_frame(is_cfg, 16'(len_pick), word, $urandom_range(0, len_pick + 9), 8);
        end else if (pick < 88) begin
          len_pick = len_limit + 1 + $urandom_range(0, 65534 - len_limit);
          send_frame(is_cfg, 16'(len_pick), word, -1, 8);
        end else if (pick < 95) begin
          repeat ($urandom_range(1, 20)) send_beat(1'b1, 8'd0);
        end else begin
          repeat ($urandom_range(1, 6)) send_beat(1'b0, 8'($urandom_range(0, 255)));
        end
      end
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sink_hold = 0;
      report.ready <= 1'b0;
    end else begin
      if (report.valid && report.ready) begin
        sink_hold = no_idle ? 0 : $urandom_range(0, 8);
      end else if (sink_hold != 0) begin
        sink_hold--;
      end
      report.ready <= (sink_hold == 0);
    end
  end

  always @(posedge clk) begin
    report_t want;
    if (!rst && report.valid && report.ready) begin
      if (expected_reports.size() == 0) begin
        bad_beats++;
        if (bad_beats <= 10) $display("%0t: result beat with nothing expected", $time);
      end else begin
        want = expected_reports.pop_front();
        if (report.report_valid !== want.rep_ok || report.distance_bits !== want.dist_bits ||
            report.config_frame_seen !== want.cfg_ok || report.connected !== want.conn) begin
          bad_beats++;
          if (bad_beats <= 10) begin
            $display("%0t: expected rep=%0b dist=%h cfg=%0b conn=%0b",
                     $time, want.rep_ok, want.dist_bits, want.cfg_ok, want.conn);
            $display("%0t:      got rep=%0b dist=%h cfg=%0b conn=%0b",
                     $time, report.report_valid, report.distance_bits,
                     report.config_frame_seen, report.connected);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, expected_reports.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    feed.valid <= 1'b0;
    feed.func <= 1'b0;
    feed.rx_byte <= 8'd0;
    cfg_write <= 1'b0;
    cfg_index <= CFG_IDX_MAX_LEN;
    cfg_data <= 16'd0;
    rx_phase = PH_H1;
    in_config = 1'b0;
    frame_len = 16'd0;
    pay_seen = 16'd0;
    pay_window = 32'd0;
    held_distance = 32'd0;
    quiet_ms = 16'd0;
    len_limit = MAX_LEN_RESET;
    timeout_ms = TIMEOUT_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_clean_frames();
    test_broken_frames();
    test_register_extremes();
    test_link_timeout();
    test_random_traffic();
    settle();
    bad_beats += expected_reports.size();
    $display("Sent %0d beats, %0d of them ticks, across ten register settings.",
             beats_sent, ticks_sent);
    $display("Checked %0d distance reports and %0d config frames; %0d bad beats.",
             reports_seen, config_frames_seen, bad_beats);
    if (bad_beats == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
